### sv/swts_pkg.sv
// Shared constants and request codes for the sliding-window timing statistics block.
`timescale 1ns / 1ps
`default_nettype none

package swts_pkg;

  localparam int unsigned TimeW     = 48;
  localparam int unsigned DurW      = 32;
  localparam int unsigned SumW      = 38;
  localparam int unsigned CountOutW = 7;
  localparam int unsigned PeriodW   = 32;

  localparam int unsigned WindowSizeDefault = 64;
  localparam int unsigned MinSpanCount      = 2;

  localparam logic [PeriodW-1:0] PeriodReset = 32'd1000000;

  localparam logic ReqPush  = 1'b0;
  localparam logic ReqClear = 1'b1;

endpackage

`default_nettype wire

### sv/swts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module swts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### sv/sliding_window_timing_stats.sv
// Top level: ring of timing records with running duration sum, span and refresh flag.
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_stall_o   req_type_i, time_us_i, duration_us_i
//   out       result     out_valid_o / out_stall_i refresh_o, window_sum_us_o, span_us_o,
//                                                  fill_count_o
//   cfg       write      cfg_we_i                  cfg_wdata_i (refresh period)
//
// One request is taken per cycle unless stalled; its result is in the output register in
// the cycle after. The two ring RAMs are read ahead at the slots the next push needs, so no
// push waits on a read. Reset empties the window and loads the default refresh period; the
// ring contents are not cleared. A held result stalls the input only while it is not taken.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_timing_stats #(
  parameter int unsigned WINDOW_SIZE = swts_pkg::WindowSizeDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,

  input  wire logic                                  cfg_we_i,
  input  wire logic        [swts_pkg::PeriodW-1:0]   cfg_wdata_i,

  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  req_type_i,
  input  wire logic        [swts_pkg::TimeW-1:0]     time_us_i,
  input  wire logic        [swts_pkg::DurW-1:0]      duration_us_i,

  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       refresh_o,
  output logic             [swts_pkg::SumW-1:0]      window_sum_us_o,
  output logic signed      [swts_pkg::TimeW-1:0]     span_us_o,
  output logic             [swts_pkg::CountOutW-1:0] fill_count_o
);

  localparam int unsigned AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CW = $clog2(WINDOW_SIZE + 1);
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_SIZE - 1);
  localparam logic [CW-1:0] FullCount = CW'(WINDOW_SIZE);

  // state
  logic [AW-1:0]                  ws_q, ws_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [swts_pkg::SumW-1:0]      sum_q, sum_d;
  logic [swts_pkg::TimeW-1:0]     last_ref_q, last_ref_d;
  logic [swts_pkg::TimeW-1:0]     first_q, first_d;
  logic [swts_pkg::PeriodW-1:0]   period_q;

  // bypass for a read that met a write to the same slot
  logic                           fwd_dur_q, fwd_start_q;
  logic [swts_pkg::DurW-1:0]      last_d_q;
  logic [swts_pkg::TimeW-1:0]     last_t_q;

  logic                           out_valid_q;
  logic                           refresh_q;
  logic [swts_pkg::SumW-1:0]      wsum_q;
  logic [swts_pkg::TimeW-1:0]     span_q;
  logic [swts_pkg::CountOutW-1:0] fill_q;

  logic                           accept;
  logic                           push;
  logic [AW-1:0]                  ws_inc;
  logic [AW-1:0]                  rd_start_addr;
  logic [swts_pkg::DurW-1:0]      dur_rdata, old_dur;
  logic [swts_pkg::TimeW-1:0]     start_rdata, old_start;
  logic                           full_before, full_after;
  logic [CW-1:0]                  cnt_push;
  logic [swts_pkg::SumW-1:0]      sum_push;
  logic [swts_pkg::TimeW-1:0]     since_ref;
  logic                           refresh_hit;
  logic [swts_pkg::TimeW-1:0]     span_push;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (req_type_i == swts_pkg::ReqPush);

  assign ws_inc        = (ws_q == LastSlot) ? '0 : ws_q + 1'b1;
  assign rd_start_addr = (ws_d == LastSlot) ? '0 : ws_d + 1'b1;

  swts_ram #(
    .Width (swts_pkg::DurW),
    .Depth (WINDOW_SIZE)
  ) u_dur_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (ws_q),
    .wdata_i (duration_us_i),
    .raddr_i (ws_d),
    .rdata_o (dur_rdata)
  );

  swts_ram #(
    .Width (swts_pkg::TimeW),
    .Depth (WINDOW_SIZE)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (ws_q),
    .wdata_i (time_us_i),
    .raddr_i (rd_start_addr),
    .rdata_o (start_rdata)
  );

  assign old_dur   = fwd_dur_q   ? last_d_q : dur_rdata;
  assign old_start = fwd_start_q ? last_t_q : start_rdata;

  assign full_before = (cnt_q == FullCount);
  assign cnt_push    = full_before ? cnt_q : cnt_q + 1'b1;
  assign full_after  = (cnt_push == FullCount);

  // drop the evicted duration once the ring is full
  assign sum_push = sum_q - (full_before ? swts_pkg::SumW'(old_dur) : '0)
                  + swts_pkg::SumW'(duration_us_i);

  assign since_ref   = time_us_i - last_ref_q;
  assign refresh_hit = $signed({since_ref[swts_pkg::TimeW-1], since_ref})
                    >= $signed({17'd0, period_q});

  always_comb begin
    span_push = '0;
    if (full_after) begin
      if (WINDOW_SIZE > 1) begin
        span_push = time_us_i - old_start;
      end
    end else if (32'(cnt_push) > swts_pkg::MinSpanCount) begin
      span_push = time_us_i - first_q;
    end
  end

  always_comb begin
    ws_d       = ws_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    last_ref_d = last_ref_q;
    first_d    = first_q;
    if (accept) begin
      case (req_type_i)
        swts_pkg::ReqClear: begin
          ws_d       = '0;
          cnt_d      = '0;
          sum_d      = '0;
          last_ref_d = time_us_i;
        end
        swts_pkg::ReqPush: begin
          ws_d  = ws_inc;
          cnt_d = cnt_push;
          sum_d = sum_push;
          if (refresh_hit) begin
            last_ref_d = time_us_i;
          end
          if (cnt_q == '0) begin
            first_d = time_us_i;
          end
        end
        default: begin
          ws_d = ws_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      last_ref_q  <= '0;
      period_q    <= swts_pkg::PeriodReset;
      fwd_dur_q   <= 1'b0;
      fwd_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ws_q        <= ws_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      last_ref_q  <= last_ref_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      fwd_dur_q   <= push && (ws_q == ws_d);
      fwd_start_q <= push && (ws_q == rd_start_addr);
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    if (push) begin
      last_d_q <= duration_us_i;
      last_t_q <= time_us_i;
    end
    if (accept) begin
      if (push) begin
        refresh_q <= refresh_hit;
        wsum_q    <= sum_push;
        span_q    <= span_push;
        fill_q    <= swts_pkg::CountOutW'(cnt_push);
      end else begin
        refresh_q <= 1'b0;
        wsum_q    <= '0;
        span_q    <= '0;
        fill_q    <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign refresh_o       = refresh_q;
  assign window_sum_us_o = wsum_q;
  assign span_us_o       = $signed(span_q);
  assign fill_count_o    = fill_q;

endmodule

`default_nettype wire
